>>> hdl/prf_pkg.sv
// Package for the pairwise repulsion force block: field widths, internal
// datapath widths and fixed constants. No dependencies.
`default_nettype none

package prf_pkg;

  // interface field widths
  localparam int POS_W   = 15;
  localparam int VEL_W   = 16;
  localparam int RANGE_W = 11;
  localparam int RED_W   = 8;

  localparam logic [RANGE_W-1:0] RANGE_RESET = 11'd100;

  // offset and distance
  localparam int DELTA_W    = 16;
  localparam int SQ_W       = 30;
  localparam int D2_W       = 31;
  localparam int RANGE_SQ_W = 22;

  // square root of d2 * 256
  localparam int RAD_W     = 40;
  localparam int RAD_PAD   = RAD_W - D2_W - 8;
  localparam int ROOT_W    = 20;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int SQ_STEPS  = 2;
  localparam int SQ_STAGES = ROOT_W / SQ_STEPS;

  // force denominator d * (d + 5)^2 in Q.8 units
  localparam int EXT_W    = 21;
  localparam int EXT_SQ_W = 2 * EXT_W;
  localparam int HALF_W   = EXT_W;
  localparam int PART_W   = ROOT_W + HALF_W;
  localparam int DEN_W    = ROOT_W + EXT_SQ_W;

  localparam logic [EXT_W-1:0] SOFT_Q8 = 21'd1280;

  // rounded division
  localparam int NUM_MAG_W  = 23;
  localparam int PUSH_SHIFT = 29;
  localparam int DIV_W      = DEN_W + 1;
  localparam int Q_W        = 17;
  localparam logic [NUM_MAG_W-1:0] FORCE_K = 23'd200;

  // red level
  localparam int RD_W   = RANGE_W + 8;
  localparam int RNUM_W = RD_W + 8;

  localparam logic signed [VEL_W-1:0] VEL_MAX = 16'sh7FFF;
  localparam logic signed [VEL_W-1:0] VEL_MIN = 16'sh8000;

endpackage

`default_nettype wire

>>> hdl/prf_if.sv
// Channel interfaces of the pairwise repulsion force block: pair input,
// result output and range register write. Depends on prf_pkg.
`default_nettype none

interface prf_pair_if;
  import prf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    same_particle;
  logic [POS_W-1:0]        self_x;
  logic [POS_W-1:0]        self_y;
  logic [POS_W-1:0]        other_x;
  logic [POS_W-1:0]        other_y;
  logic signed [VEL_W-1:0] self_vx;
  logic signed [VEL_W-1:0] self_vy;

  modport source(output valid, same_particle, self_x, self_y, other_x, other_y,
                 self_vx, self_vy, input ready);
  modport sink(input valid, same_particle, self_x, self_y, other_x, other_y,
               self_vx, self_vy, output ready);
endinterface

interface prf_result_if;
  import prf_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    interacted;
  logic signed [VEL_W-1:0] new_vx;
  logic signed [VEL_W-1:0] new_vy;
  logic [RED_W-1:0]        red_level;

  modport source(output valid, interacted, new_vx, new_vy, red_level, input ready);
  modport sink(input valid, interacted, new_vx, new_vy, red_level, output ready);
endinterface

interface prf_cfg_if;
  import prf_pkg::*;
  logic               valid;
  logic               ready;
  logic [RANGE_W-1:0] interaction_range;

  modport source(output valid, interaction_range, input ready);
  modport sink(input valid, interaction_range, output ready);
endinterface

`default_nettype wire

>>> hdl/prf_sqrt_pipe.sv
// Pipelined integer square root of d2 * 256, two root bits per stage.
// Depends on prf_pkg.
`default_nettype none

module prf_sqrt_pipe #(
  parameter int TAG_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [prf_pkg::D2_W-1:0]   d2,
  input  logic [TAG_W-1:0]           tag_in,
  output logic                       out_valid,
  output logic [prf_pkg::ROOT_W-1:0] root_out,
  output logic [TAG_W-1:0]           tag_out
);
  import prf_pkg::*;

  logic [SQ_STAGES-1:0] vld;
  logic [RAD_W-1:0]     rad  [SQ_STAGES];
  logic [SQ_REM_W-1:0]  rem  [SQ_STAGES];
  logic [ROOT_W-1:0]    root [SQ_STAGES];
  logic [TAG_W-1:0]     tag  [SQ_STAGES];

  for (genvar s = 0; s < SQ_STAGES; s++) begin : g_stage
    logic                vld_p;
    logic [RAD_W-1:0]    rad_p, rad_c;
    logic [SQ_REM_W-1:0] rem_p, rem_c;
    logic [ROOT_W-1:0]   root_p, root_c;
    logic [TAG_W-1:0]    tag_p;

    if (s == 0) begin : g_first
      assign vld_p  = in_valid;
      assign rad_p  = {{RAD_PAD{1'b0}}, d2, 8'b0};
      assign rem_p  = '0;
      assign root_p = '0;
      assign tag_p  = tag_in;
    end else begin : g_next
      assign vld_p  = vld[s-1];
      assign rad_p  = rad[s-1];
      assign rem_p  = rem[s-1];
      assign root_p = root[s-1];
      assign tag_p  = tag[s-1];
    end

    always_comb begin : step
      logic [SQ_REM_W-1:0] r;
      logic [SQ_REM_W-1:0] t;
      logic [SQ_REM_W-1:0] trial;
      logic [ROOT_W-1:0]   q;
      logic [RAD_W-1:0]    a;
      r = rem_p;
      q = root_p;
      a = rad_p;
      for (int j = 0; j < SQ_STEPS; j++) begin
        // bring down the next radicand pair, try (root << 2) | 1
        t     = {r[SQ_REM_W-3:0], a[RAD_W-1 -: 2]};
        a     = a << 2;
        trial = {1'b0, q, 2'b01};
        if (t >= trial) begin
          r = t - trial;
          q = {q[ROOT_W-2:0], 1'b1};
        end else begin
          r = t;
          q = {q[ROOT_W-2:0], 1'b0};
        end
      end
      rem_c  = r;
      root_c = q;
      rad_c  = a;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[s]  <= rad_c;
        rem[s]  <= rem_c;
        root[s] <= root_c;
        tag[s]  <= tag_p;
      end
    end
  end

  assign out_valid = vld[SQ_STAGES-1];
  assign root_out  = root[SQ_STAGES-1];
  assign tag_out   = tag[SQ_STAGES-1];

endmodule

`default_nettype wire

>>> hdl/prf_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, with an
// overflow flag for quotients that do not fit. Depends on prf_pkg.
`default_nettype none

module prf_div_pipe #(
  parameter int NUM_W = 8,
  parameter int DEN_W = 8,
  parameter int Q_W   = 4,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_valid,
  output logic [Q_W-1:0]   quot,
  output logic             ovf,
  output logic [TAG_W-1:0] tag_out
);
  import prf_pkg::*;

  localparam int REM_W  = DEN_W + 1;
  localparam int WIDE_W = NUM_W + REM_W;
  localparam int STAGES = Q_W + 1;

  logic [STAGES-1:0] vld;
  logic [STAGES-1:0] over;
  logic [REM_W-1:0]  rem [STAGES];
  logic [Q_W-1:0]    lo  [STAGES];
  logic [Q_W-1:0]    q   [STAGES];
  logic [DEN_W-1:0]  dv  [STAGES];
  logic [TAG_W-1:0]  tag [STAGES];

  // entry: high part of the numerator, overflow when it reaches the divisor
  logic [WIDE_W-1:0] wide_hi;
  assign wide_hi = {{REM_W{1'b0}}, num} >> Q_W;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else if (en) begin
      vld[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      over[0] <= (wide_hi >= WIDE_W'(den));
      rem[0]  <= wide_hi[REM_W-1:0];
      lo[0]   <= num[Q_W-1:0];
      q[0]    <= '0;
      dv[0]   <= den;
      tag[0]  <= tag_in;
    end
  end

  for (genvar s = 1; s < STAGES; s++) begin : g_stage
    logic [REM_W-1:0] t;
    logic             ge;

    assign t  = {rem[s-1][REM_W-2:0], lo[s-1][Q_W-1]};
    assign ge = (t >= {1'b0, dv[s-1]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s] <= 1'b0;
      end else if (en) begin
        vld[s] <= vld[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        over[s] <= over[s-1];
        rem[s]  <= ge ? (t - {1'b0, dv[s-1]}) : t;
        lo[s]   <= lo[s-1] << 1;
        q[s]    <= {q[s-1][Q_W-2:0], ge};
        dv[s]   <= dv[s-1];
        tag[s]  <= tag[s-1];
      end
    end
  end

  assign out_valid = vld[STAGES-1];
  assign quot      = q[STAGES-1];
  assign ovf       = over[STAGES-1];
  assign tag_out   = tag[STAGES-1];

endmodule

`default_nettype wire

>>> hdl/pairwise_repulsion_force.sv
// Top level of the pairwise repulsion force block: offset, distance, root,
// force division and red level. Depends on prf_pkg, prf_if, prf_sqrt_pipe, prf_div_pipe.
//
//   channel | modport       | beat
//   --------+---------------+----------------------------------------------
//   cfg     | prf_cfg_if    | interaction_range write, always ready
//   pair    | prf_pair_if   | two positions and the acted-on velocity
//   result  | prf_result_if | interacted, new velocity, red level
//
// One pair enters per cycle while the skid register is empty; each pair then
// passes 3 distance stages, 10 root stages, 4 denominator stages, 18 divider
// stages and 1 output register. Reset clears all valid bits and the skid
// full flag and loads interaction_range with 100. When a result is refused,
// it moves into the skid register and the whole pipeline holds until it drains.
`default_nettype none

module pairwise_repulsion_force (
  input logic          clk,
  input logic          rst,
  prf_cfg_if.sink      cfg,
  prf_pair_if.sink     pair,
  prf_result_if.source result
);
  import prf_pkg::*;

  typedef struct packed {
    logic                      hit;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [VEL_W-1:0]   vx;
    logic signed [VEL_W-1:0]   vy;
  } sq_tag_t;

  typedef struct packed {
    logic                    hit;
    logic                    zero;
    logic                    neg_x;
    logic                    neg_y;
    logic signed [VEL_W-1:0] vx;
    logic signed [VEL_W-1:0] vy;
  } side_t;

  typedef struct packed {
    logic                    zero;
    logic                    neg;
    logic signed [VEL_W-1:0] v;
  } xtag_t;

  typedef struct packed {
    logic                    neg;
    logic signed [VEL_W-1:0] v;
  } ytag_t;

  typedef struct packed {
    logic                    interacted;
    logic signed [VEL_W-1:0] new_vx;
    logic signed [VEL_W-1:0] new_vy;
    logic [RED_W-1:0]        red_level;
  } res_t;

  localparam int SQ_TAG_W = $bits(sq_tag_t);
  localparam int XTAG_W   = $bits(xtag_t);
  localparam int YTAG_W   = $bits(ytag_t);

  // range register
  logic [RANGE_W-1:0]    interaction_range;
  logic [RANGE_SQ_W-1:0] range_sq;
  logic [RD_W-1:0]       rd;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      interaction_range <= RANGE_RESET;
    end else if (cfg.valid) begin
      interaction_range <= cfg.interaction_range;
    end
  end

  always_ff @(posedge clk) begin
    range_sq <= RANGE_SQ_W'(interaction_range) * RANGE_SQ_W'(interaction_range);
  end

  assign rd = {interaction_range, 8'b0};

  logic en;
  logic skid_full;
  assign en         = !skid_full;
  assign pair.ready = en;

  // stage 1: offsets
  logic                      v1, same1;
  logic signed [DELTA_W-1:0] dx1, dy1;
  logic signed [VEL_W-1:0]   vx1, vy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pair.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      same1 <= pair.same_particle;
      dx1   <= $signed({1'b0, pair.other_x}) - $signed({1'b0, pair.self_x});
      dy1   <= $signed({1'b0, pair.other_y}) - $signed({1'b0, pair.self_y});
      vx1   <= pair.self_vx;
      vy1   <= pair.self_vy;
    end
  end

  // stage 2: squares
  logic signed [2*DELTA_W-1:0] px, py;
  logic                        v2, same2;
  logic [SQ_W-1:0]             sqx2, sqy2;
  logic signed [DELTA_W-1:0]   dx2, dy2;
  logic signed [VEL_W-1:0]     vx2, vy2;

  assign px = dx1 * dx1;
  assign py = dy1 * dy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      same2 <= same1;
      sqx2  <= px[SQ_W-1:0];
      sqy2  <= py[SQ_W-1:0];
      dx2   <= dx1;
      dy2   <= dy1;
      vx2   <= vx1;
      vy2   <= vy1;
    end
  end

  // stage 3: distance squared and range test
  logic [D2_W-1:0] d2_sum;
  logic            v3;
  logic [D2_W-1:0] d2_3;
  sq_tag_t         tag3;

  assign d2_sum = D2_W'(sqx2) + D2_W'(sqy2);

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_3     <= d2_sum;
      tag3.hit <= !same2 && (d2_sum < D2_W'({range_sq, 8'b0}));
      tag3.dx  <= dx2;
      tag3.dy  <= dy2;
      tag3.vx  <= vx2;
      tag3.vy  <= vy2;
    end
  end

  // root
  logic              v_sq;
  logic [ROOT_W-1:0] root_sq;
  sq_tag_t           tag_sq;

  prf_sqrt_pipe #(
    .TAG_W(SQ_TAG_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (v3),
    .d2       (d2_3),
    .tag_in   (tag3),
    .out_valid(v_sq),
    .root_out (root_sq),
    .tag_out  (tag_sq)
  );

  // stage 4: (d + 5)^2, force numerators, red numerator
  logic [EXT_W-1:0]     e8;
  logic [EXT_SQ_W-1:0]  e8sq_c;
  logic [DELTA_W-1:0]   absx, absy;
  logic [RD_W-1:0]      diff;
  logic                 v4;
  logic [ROOT_W-1:0]    d8_4;
  logic [EXT_SQ_W-1:0]  e8sq4;
  logic [NUM_MAG_W-1:0] nx4, ny4;
  logic [RNUM_W-1:0]    rn4;
  side_t                side4;

  assign e8     = EXT_W'(root_sq) + SOFT_Q8;
  assign e8sq_c = e8 * e8;
  assign absx   = tag_sq.dx[DELTA_W-1] ? DELTA_W'(-tag_sq.dx) : DELTA_W'(tag_sq.dx);
  assign absy   = tag_sq.dy[DELTA_W-1] ? DELTA_W'(-tag_sq.dy) : DELTA_W'(tag_sq.dy);
  assign diff   = rd - RD_W'(root_sq);

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v_sq;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d8_4        <= root_sq;
      e8sq4       <= e8sq_c;
      nx4         <= FORCE_K * NUM_MAG_W'(absx);
      ny4         <= FORCE_K * NUM_MAG_W'(absy);
      rn4         <= {diff, 8'b0} - RNUM_W'(diff);
      side4.hit   <= tag_sq.hit;
      side4.zero  <= (root_sq == '0);
      side4.neg_x <= tag_sq.dx[DELTA_W-1];
      side4.neg_y <= tag_sq.dy[DELTA_W-1];
      side4.vx    <= tag_sq.vx;
      side4.vy    <= tag_sq.vy;
    end
  end

  // stage 5: partial products of d * (d + 5)^2
  logic [PART_W-1:0]    pl5, ph5;
  logic                 v5;
  logic [NUM_MAG_W-1:0] nx5, ny5;
  logic [RNUM_W-1:0]    rn5;
  side_t                side5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pl5   <= d8_4 * e8sq4[HALF_W-1:0];
      ph5   <= d8_4 * e8sq4[EXT_SQ_W-1:HALF_W];
      nx5   <= nx4;
      ny5   <= ny4;
      rn5   <= rn4;
      side5 <= side4;
    end
  end

  // stage 6: denominator
  logic [DEN_W-1:0]     den6;
  logic                 v6;
  logic [NUM_MAG_W-1:0] nx6, ny6;
  logic [RNUM_W-1:0]    rn6;
  side_t                side6;

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else if (en) begin
      v6 <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den6  <= DEN_W'(pl5) + (DEN_W'(ph5) << HALF_W);
      nx6   <= nx5;
      ny6   <= ny5;
      rn6   <= rn5;
      side6 <= side5;
    end
  end

  // stage 7: rounding form, q = (2*num + den) / (2*den)
  logic [DIV_W-1:0]  numx7, numy7, den7;
  logic              v7;
  logic [RNUM_W-1:0] rn7;
  side_t             side7;

  always_ff @(posedge clk) begin
    if (rst) begin
      v7 <= 1'b0;
    end else if (en) begin
      v7 <= v6;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      numx7 <= DIV_W'({nx6, {PUSH_SHIFT{1'b0}}}) + DIV_W'(den6);
      numy7 <= DIV_W'({ny6, {PUSH_SHIFT{1'b0}}}) + DIV_W'(den6);
      den7  <= {den6, 1'b0};
      rn7   <= rn6;
      side7 <= side6;
    end
  end

  // dividers
  xtag_t          xtag_in, xtag_out;
  ytag_t          ytag_in, ytag_out;
  logic           vdx, vdy, vdr;
  logic [Q_W-1:0] qx, qy, qr;
  logic           ovx, ovy, ovr;
  logic           hit_d;

  assign xtag_in = '{zero: side7.zero, neg: side7.neg_x, v: side7.vx};
  assign ytag_in = '{neg: side7.neg_y, v: side7.vy};

  prf_div_pipe #(
    .NUM_W(DIV_W), .DEN_W(DIV_W), .Q_W(Q_W), .TAG_W(XTAG_W)
  ) u_div_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7),
    .num(numx7), .den(den7), .tag_in(xtag_in),
    .out_valid(vdx), .quot(qx), .ovf(ovx), .tag_out(xtag_out)
  );

  prf_div_pipe #(
    .NUM_W(DIV_W), .DEN_W(DIV_W), .Q_W(Q_W), .TAG_W(YTAG_W)
  ) u_div_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7),
    .num(numy7), .den(den7), .tag_in(ytag_in),
    .out_valid(vdy), .quot(qy), .ovf(ovy), .tag_out(ytag_out)
  );

  prf_div_pipe #(
    .NUM_W(RNUM_W), .DEN_W(RD_W), .Q_W(Q_W), .TAG_W(1)
  ) u_div_red (
    .clk(clk), .rst(rst), .en(en), .in_valid(v7),
    .num(rn7), .den(rd), .tag_in(side7.hit),
    .out_valid(vdr), .quot(qr), .ovf(ovr), .tag_out(hit_d)
  );

  function automatic logic signed [VEL_W-1:0] push_vel(
    input logic signed [VEL_W-1:0] v,
    input logic [Q_W-1:0]          q,
    input logic                    ovf,
    input logic                    neg,
    input logic                    apply
  );
    logic signed [VEL_W+2:0] s;
    logic signed [VEL_W-1:0] r;
    if (neg) begin
      s = (VEL_W+3)'(v) + $signed({2'b00, q});
    end else begin
      s = (VEL_W+3)'(v) - $signed({2'b00, q});
    end
    if (!apply) begin
      r = v;
    end else if (ovf) begin
      r = neg ? VEL_MAX : VEL_MIN;
    end else if (s > (VEL_W+3)'(VEL_MAX)) begin
      r = VEL_MAX;
    end else if (s < (VEL_W+3)'(VEL_MIN)) begin
      r = VEL_MIN;
    end else begin
      r = s[VEL_W-1:0];
    end
    return r;
  endfunction

  // output register
  logic apply;
  res_t res_c, p_data, skid_data;
  logic p_valid;

  assign apply = hit_d && !xtag_out.zero;

  always_comb begin
    res_c.interacted = hit_d;
    res_c.new_vx     = push_vel(xtag_out.v, qx, ovx, xtag_out.neg, apply);
    res_c.new_vy     = push_vel(ytag_out.v, qy, ovy, ytag_out.neg, apply);
    // quotient never exceeds 255 for a pair in range
    res_c.red_level  = (hit_d && !ovr) ? qr[RED_W-1:0] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (en) begin
      p_valid <= vdx & vdy & vdr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_data <= res_c;
    end
  end

  // skid: park a refused result, hold the pipeline until it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full && result.ready) begin
      skid_full <= 1'b0;
    end else if (!skid_full && p_valid && !result.ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full) begin
      skid_data <= p_data;
    end
  end

  res_t res_out;
  assign res_out           = skid_full ? skid_data : p_data;
  assign result.valid      = skid_full | p_valid;
  assign result.interacted = res_out.interacted;
  assign result.new_vx     = res_out.new_vx;
  assign result.new_vy     = res_out.new_vy;
  assign result.red_level  = res_out.red_level;

endmodule

`default_nettype wire

>>> hdl/prf_checker.sv
// Port checker for the pairwise repulsion force block, bound to the top level.
// Depends on prf_pkg and pairwise_repulsion_force.
`default_nettype none

module prf_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             pair_valid,
  input logic                             pair_ready,
  input logic                             res_valid,
  input logic                             res_ready,
  input logic                             interacted,
  input logic signed [prf_pkg::VEL_W-1:0] new_vx,
  input logic signed [prf_pkg::VEL_W-1:0] new_vy,
  input logic [prf_pkg::RED_W-1:0]        red_level
);
  import prf_pkg::*;

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid right after reset");

  // a refused result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(interacted) && $stable(new_vx)
      && $stable(new_vy) && $stable(red_level))
    else $error("refused result changed");

  // no interaction means no red
  a_red_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && !interacted |-> red_level == '0)
    else $error("red level set without interaction");

  // input backpressure only follows a refused result
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !pair_ready |-> $past(res_valid && !res_ready))
    else $error("pair not ready without output stall");

  // a stalled pair always has a result waiting on the output
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    pair_valid && !pair_ready |-> res_valid)
    else $error("input stalled while no result is shown");

endmodule

bind pairwise_repulsion_force prf_checker u_prf_checker (
  .clk       (clk),
  .rst       (rst),
  .pair_valid(pair.valid),
  .pair_ready(pair.ready),
  .res_valid (result.valid),
  .res_ready (result.ready),
  .interacted(result.interacted),
  .new_vx    (result.new_vx),
  .new_vy    (result.new_vy),
  .red_level (result.red_level)
);

`default_nettype wire
